FILE: sv/lifn_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes, reset values and fixed-point helpers of the LIF network block.
package lifn_pkg;

    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 72;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_RESET    = 3'd1,
        CMD_WEIGHT   = 3'd2,
        CMD_CLASS    = 3'd3,
        CMD_LANDMARK = 3'd4,
        CMD_INIT     = 3'd5,
        CMD_RSVD6    = 3'd6,
        CMD_RSVD7    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_SYN_DECAY = 3'd0,
        CFG_LEAK      = 3'd1,
        CFG_DT        = 3'd2,
        CFG_THRESH    = 3'd3,
        CFG_RESET_POT = 3'd4,
        CFG_REFR_LEN  = 3'd5,
        CFG_NEURONS   = 3'd6,
        CFG_WEDGES    = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] CLASS_LEFT  = 2'd1;
    localparam logic [1:0] CLASS_RIGHT = 2'd2;

    localparam logic [16:0] RST_SYN_DECAY = 17'd58982;
    localparam logic [16:0] RST_LEAK      = 17'd6554;
    localparam logic [16:0] RST_DT        = 17'd65536;
    localparam logic [31:0] RST_THRESH    = 32'd65536;
    localparam logic [31:0] RST_RESET_POT = 32'd0;
    localparam logic [15:0] RST_REFR_LEN  = 16'd2;
    localparam logic [6:0]  RST_NEURONS   = 7'd64;
    localparam logic [3:0]  RST_WEDGES    = 4'd8;

    typedef struct packed {
        logic [31:0] pot;
        logic [31:0] syn;
        logic [15:0] refr;
    } nstate_t;

    typedef struct packed {
        logic        we_weight;
        logic        we_class;
        logic        we_land;
        logic        we_init;
        logic [5:0]  neuron;
        logic [5:0]  source;
        logic [2:0]  wedge;
        logic [31:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic       w_en;
        logic [5:0] w_pre;
        logic [5:0] w_post;
        logic       n_en;
        logic [5:0] n_idx;
        logic [3:0] wedge;
    } tbl_rd_t;

    typedef struct packed {
        logic [31:0] weight;
        logic [1:0]  cls;
        logic [31:0] land;
        logic [31:0] init;
    } tbl_q_t;

    // Signed Q16.16 times unsigned Q1.16 of 17 bits, floored, wrapped to 32 bits.
    function automatic logic [31:0] qmul_u17(logic [31:0] a, logic [16:0] b);
        logic signed [49:0] p;
        p = $signed(a) * $signed({1'b0, b});
        return p[47:16];
    endfunction

    function automatic logic [31:0] qmul_s32(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p[47:16];
    endfunction

endpackage

FILE: sv/lif_spiking_network_tick.sv
`timescale 1ns / 1ps
// Top level of the LIF network: command decode, tick sequencer and Q16.16 neuron update.
//
//  Channel  | Ports                        | Direction | Contents
//  ---------+------------------------------+-----------+---------------------------------
//  s_       | s_tvalid s_tready s_tdata    | in        | command in tuser, table and tick
//           | s_tuser                      |           | fields in tdata
//  m_       | m_tvalid m_tready m_tdata    | out       | spike mask and count per tick
//  cfg_     | cfg_valid cfg_ready          | in        | register index and write data
//           | cfg_index cfg_data           |           |
//
// The weight memory has one read port, so during a tick each of the N neurons in use
// gathers its N presynaptic weights one per cycle. A reset command reads and rewrites
// each neuron in use in turn; table writes and unknown commands finish on acceptance.
// aresetn is synchronous; it resets the settings, the control state and the neuron state.
// s_tready is high only when no command is in progress; a finished tick waits for the
// result register to be free, so a stalled master side holds the block in that state.
module lif_spiking_network_tick #(
    parameter int MAX_NEURONS = 64,
    parameter int MAX_WEDGES  = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // neuron_index[5:0] source_index[11:6] wedge_index[14:12] table_value[46:15]
    // drive_left[78:47] drive_right[110:79] landmark_on[111] lm_sector[119:112]
    // landmark_strength[151:120]
    input  logic [lifn_pkg::S_TDATA_W-1:0] s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // spike_mask[63:0] spike_count[70:64], bit 71 zero
    output logic [lifn_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int IW = $clog2(MAX_NEURONS);
    localparam int M_TDATA_WL = lifn_pkg::M_TDATA_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_MOD  = 12'b000000000010,
        S_ACC  = 12'b000000000100,
        S_RD   = 12'b000000001000,
        S_MUL  = 12'b000000010000,
        S_SUM  = 12'b000000100000,
        S_DIF  = 12'b000001000000,
        S_DV   = 12'b000010000000,
        S_WB   = 12'b000100000000,
        S_OUT  = 12'b001000000000,
        S_RRD  = 12'b010000000000,
        S_RWR  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [16:0] decay_reg, leak_reg, dt_reg;
    logic [31:0] thresh_reg, reset_pot_reg;
    logic [15:0] refr_len_reg;
    logic [6:0]  ncount_reg;
    logic [3:0]  wcount_reg;

    // input fields
    lifn_pkg::cmd_t cmd;
    logic [5:0]  in_ni, in_si;
    logic [2:0]  in_wi;
    logic [31:0] in_tv, in_dl, in_dr, in_ls;
    logic        in_on;
    logic [7:0]  in_lw;
    logic        s_acc;

    // sequencing
    logic [6:0]  n_act;
    logic [4:0]  w_act;
    logic [6:0]  i_reg, pre_reg;
    logic [2:0]  mod_cnt_reg;
    logic        wv_reg, wf_reg, issue, last;
    logic        out_free, m_valid_reg;
    logic [MAX_NEURONS-1:0] flags_reg, newflags_reg, low_mask;

    // tick datapath
    logic [31:0] dl_reg, dr_reg, ls_reg;
    logic        on_reg;
    logic [7:0]  lw_sh_reg;
    logic [4:0]  rem_reg, mod_t, mod_step;
    logic [31:0] acc_reg, psyn_reg, plm_reg, pleak_reg, pot_reg, base_reg;
    logic [15:0] refr_reg;
    logic [31:0] syn_new_reg, ext_reg, diff_reg, dv_reg, v1;
    logic        spike;
    logic [63:0] mask_reg;
    logic [6:0]  cnt_reg;
    logic [M_TDATA_WL-1:0] m_data_reg;

    lifn_pkg::tbl_wr_t tbl_wr;
    lifn_pkg::tbl_rd_t tbl_rd;
    lifn_pkg::tbl_q_t  tbl_q;
    lifn_pkg::nstate_t st_q, st_wr;
    logic st_rd_en, st_wr_en;

    assign cmd   = lifn_pkg::cmd_t'(s_tuser);
    assign in_ni = s_tdata[5:0];
    assign in_si = s_tdata[11:6];
    assign in_wi = s_tdata[14:12];
    assign in_tv = s_tdata[46:15];
    assign in_dl = s_tdata[78:47];
    assign in_dr = s_tdata[110:79];
    assign in_on = s_tdata[111];
    assign in_lw = s_tdata[119:112];
    assign in_ls = s_tdata[151:120];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    assign n_act = (ncount_reg > 7'(MAX_NEURONS)) ? 7'(MAX_NEURONS) : ncount_reg;
    assign w_act = (wcount_reg == 4'd0) ? 5'd1 :
                   ({1'b0, wcount_reg} > 5'(MAX_WEDGES)) ? 5'(MAX_WEDGES) : {1'b0, wcount_reg};
    assign issue = (pre_reg < n_act);
    assign last  = (7'(i_reg + 7'd1) >= n_act);

    // One bit of the landmark sector mod active wedges per cycle, most significant bit first.
    assign mod_t    = {rem_reg[3:0], lw_sh_reg[7]};
    assign mod_step = (mod_t >= w_act) ? 5'(mod_t - w_act) : mod_t;

    always_comb begin
        for (int k = 0; k < MAX_NEURONS; k++) begin
            low_mask[k] = (k < int'(n_act));
        end
    end

    // table writes straight from the accepted command
    always_comb begin
        tbl_wr.neuron    = in_ni;
        tbl_wr.source    = in_si;
        tbl_wr.wedge     = in_wi;
        tbl_wr.data      = in_tv;
        tbl_wr.we_weight = s_acc && (cmd == lifn_pkg::CMD_WEIGHT) &&
                           (int'(in_ni) < MAX_NEURONS) && (int'(in_si) < MAX_NEURONS);
        tbl_wr.we_class  = s_acc && (cmd == lifn_pkg::CMD_CLASS) &&
                           (int'(in_ni) < MAX_NEURONS);
        tbl_wr.we_land   = s_acc && (cmd == lifn_pkg::CMD_LANDMARK) &&
                           (int'(in_ni) < MAX_NEURONS) && (int'(in_wi) < MAX_WEDGES);
        tbl_wr.we_init   = s_acc && (cmd == lifn_pkg::CMD_INIT) &&
                           (int'(in_ni) < MAX_NEURONS);
    end

    always_comb begin
        tbl_rd.w_en   = (state_reg == S_ACC) && issue;
        tbl_rd.w_pre  = 6'(pre_reg);
        tbl_rd.w_post = 6'(i_reg);
        tbl_rd.n_en   = (state_reg == S_RD) || (state_reg == S_RRD);
        tbl_rd.n_idx  = 6'(i_reg);
        tbl_rd.wedge  = rem_reg[3:0];
    end

    // integrate only when not refractory; a refractory neuron may still spike
    assign v1    = (refr_reg == 16'd0) ? 32'(pot_reg + dv_reg) : pot_reg;
    assign spike = ($signed(v1) >= $signed(thresh_reg));

    always_comb begin
        st_rd_en = (state_reg == S_RD);
        st_wr_en = (state_reg == S_WB) || (state_reg == S_RWR);
        if (state_reg == S_RWR) begin
            st_wr.pot  = tbl_q.init;
            st_wr.syn  = '0;
            st_wr.refr = '0;
        end else begin
            st_wr.pot  = spike ? reset_pot_reg : v1;
            st_wr.syn  = syn_new_reg;
            st_wr.refr = spike ? refr_len_reg :
                         (refr_reg != 16'd0) ? 16'(refr_reg - 16'd1) : refr_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && cmd == lifn_pkg::CMD_TICK) begin
                    state_next = (n_act == 7'd0) ? S_OUT : S_MOD;
                end else if (s_acc && cmd == lifn_pkg::CMD_RESET && n_act != 7'd0) begin
                    state_next = S_RRD;
                end
            end
            S_MOD: if (mod_cnt_reg == 3'd7) state_next = S_ACC;
            S_ACC: if (!issue && !wv_reg) state_next = S_RD;
            S_RD:  state_next = S_MUL;
            S_MUL: state_next = S_SUM;
            S_SUM: state_next = S_DIF;
            S_DIF: state_next = S_DV;
            S_DV:  state_next = S_WB;
            S_WB:  state_next = last ? S_OUT : S_ACC;
            S_OUT: if (out_free) state_next = S_IDLE;
            S_RRD: state_next = S_RWR;
            S_RWR: state_next = last ? S_IDLE : S_RRD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            flags_reg     <= '0;
            i_reg         <= '0;
            pre_reg       <= '0;
            mod_cnt_reg   <= '0;
            wv_reg        <= 1'b0;
            decay_reg     <= lifn_pkg::RST_SYN_DECAY;
            leak_reg      <= lifn_pkg::RST_LEAK;
            dt_reg        <= lifn_pkg::RST_DT;
            thresh_reg    <= lifn_pkg::RST_THRESH;
            reset_pot_reg <= lifn_pkg::RST_RESET_POT;
            refr_len_reg  <= lifn_pkg::RST_REFR_LEN;
            ncount_reg    <= lifn_pkg::RST_NEURONS;
            wcount_reg    <= lifn_pkg::RST_WEDGES;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (lifn_pkg::cfg_idx_t'(cfg_index))
                    lifn_pkg::CFG_SYN_DECAY: decay_reg     <= cfg_data[16:0];
                    lifn_pkg::CFG_LEAK:      leak_reg      <= cfg_data[16:0];
                    lifn_pkg::CFG_DT:        dt_reg        <= cfg_data[16:0];
                    lifn_pkg::CFG_THRESH:    thresh_reg    <= cfg_data;
                    lifn_pkg::CFG_RESET_POT: reset_pot_reg <= cfg_data;
                    lifn_pkg::CFG_REFR_LEN:  refr_len_reg  <= cfg_data[15:0];
                    lifn_pkg::CFG_NEURONS:   ncount_reg    <= cfg_data[6:0];
                    lifn_pkg::CFG_WEDGES:    wcount_reg    <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                flags_reg   <= newflags_reg;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_acc && cmd == lifn_pkg::CMD_RESET) begin
                flags_reg <= flags_reg & ~low_mask;
            end
            if (s_acc) begin
                i_reg       <= '0;
                mod_cnt_reg <= '0;
            end
            if (state_reg == S_MOD) begin
                mod_cnt_reg <= 3'(mod_cnt_reg + 3'd1);
                pre_reg     <= '0;
            end
            wv_reg <= (state_reg == S_ACC) && issue;
            if (state_reg == S_ACC && issue) begin
                pre_reg <= 7'(pre_reg + 7'd1);
            end
            if (state_reg == S_WB || state_reg == S_RWR) begin
                i_reg   <= 7'(i_reg + 7'd1);
                pre_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && cmd == lifn_pkg::CMD_TICK) begin
            dl_reg       <= in_dl;
            dr_reg       <= in_dr;
            ls_reg       <= in_ls;
            on_reg       <= in_on;
            lw_sh_reg    <= in_lw;
            rem_reg      <= '0;
            newflags_reg <= flags_reg;
            mask_reg     <= '0;
            cnt_reg      <= '0;
            acc_reg      <= '0;
        end
        if (state_reg == S_MOD) begin
            rem_reg   <= mod_step;
            lw_sh_reg <= {lw_sh_reg[6:0], 1'b0};
        end
        if (state_reg == S_ACC) begin
            wf_reg <= flags_reg[pre_reg[IW-1:0]];
            if (wv_reg && wf_reg) begin
                acc_reg <= 32'(acc_reg + tbl_q.weight);
            end
        end
        if (state_reg == S_MUL) begin
            psyn_reg  <= lifn_pkg::qmul_u17(st_q.syn, decay_reg);
            plm_reg   <= lifn_pkg::qmul_s32(ls_reg, tbl_q.land);
            pleak_reg <= lifn_pkg::qmul_u17(st_q.pot, leak_reg);
            pot_reg   <= st_q.pot;
            refr_reg  <= st_q.refr;
            base_reg  <= (tbl_q.cls == lifn_pkg::CLASS_LEFT)  ? dl_reg :
                         (tbl_q.cls == lifn_pkg::CLASS_RIGHT) ? dr_reg : 32'd0;
        end
        if (state_reg == S_SUM) begin
            syn_new_reg <= 32'(psyn_reg + acc_reg);
            ext_reg     <= on_reg ? 32'(base_reg + plm_reg) : base_reg;
        end
        if (state_reg == S_DIF) begin
            diff_reg <= 32'(syn_new_reg + ext_reg - pleak_reg);
        end
        if (state_reg == S_DV) begin
            dv_reg <= lifn_pkg::qmul_u17(diff_reg, dt_reg);
        end
        if (state_reg == S_WB) begin
            newflags_reg[i_reg[IW-1:0]] <= spike;
            mask_reg[i_reg[IW-1:0]]     <= spike;
            cnt_reg                     <= 7'(cnt_reg + {6'd0, spike});
            acc_reg                     <= '0;
        end
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= {1'b0, cnt_reg, mask_reg};
        end
    end

    lifn_tables #(
        .MAX_NEURONS(MAX_NEURONS),
        .MAX_WEDGES (MAX_WEDGES)
    ) u_tables (
        .aclk(aclk),
        .wr  (tbl_wr),
        .rd  (tbl_rd),
        .q   (tbl_q)
    );

    lifn_state_mem #(
        .MAX_NEURONS(MAX_NEURONS)
    ) u_state (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_en  (st_rd_en),
        .rd_addr(i_reg[IW-1:0]),
        .wr_en  (st_wr_en),
        .wr_addr(i_reg[IW-1:0]),
        .wr_data(st_wr),
        .rd_data(st_q)
    );

    // A result appears only out of the output state.
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    // The weight pipeline only carries reads issued during the gather phase.
    a_weight_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        wv_reg |-> $past(state_reg == S_ACC))
        else $error("weight read valid outside the gather phase");

    // The presynaptic counter never runs past the neurons in use while gathering.
    a_pre_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC) |-> (pre_reg <= n_act))
        else $error("presynaptic index beyond neurons in use");

    // The neuron index stays below the neurons in use while a neuron is being updated.
    a_neuron_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WB || state_reg == S_RWR) |-> (i_reg < n_act))
        else $error("neuron index beyond neurons in use");
endmodule

FILE: sv/lifn_tables.sv
`timescale 1ns / 1ps
// Weight, class, landmark and initial potential memories with registered reads.
module lifn_tables #(
    parameter int MAX_NEURONS = 64,
    parameter int MAX_WEDGES  = 8
) (
    input  logic              aclk,
    input  lifn_pkg::tbl_wr_t wr,
    input  lifn_pkg::tbl_rd_t rd,
    output lifn_pkg::tbl_q_t  q
);
    localparam int IW  = $clog2(MAX_NEURONS);
    localparam int WAW = $clog2(MAX_NEURONS * MAX_NEURONS);
    localparam int LAW = $clog2(MAX_WEDGES * MAX_NEURONS);

    logic [31:0] weight_mem [MAX_NEURONS*MAX_NEURONS];
    logic [1:0]  class_mem  [MAX_NEURONS];
    logic [31:0] land_mem   [MAX_WEDGES*MAX_NEURONS];
    logic [31:0] init_mem   [MAX_NEURONS];

    logic [WAW-1:0] w_wr_addr, w_rd_addr;
    logic [LAW-1:0] l_wr_addr, l_rd_addr;
    logic [IW-1:0]  n_wr_addr, n_rd_addr;

    logic [31:0] weight_q, land_q, init_q;
    logic [1:0]  cls_q;

    assign w_wr_addr = WAW'(int'(wr.source) * MAX_NEURONS + int'(wr.neuron));
    assign w_rd_addr = WAW'(int'(rd.w_pre) * MAX_NEURONS + int'(rd.w_post));
    assign l_wr_addr = LAW'(int'(wr.wedge) * MAX_NEURONS + int'(wr.neuron));
    assign l_rd_addr = LAW'(int'(rd.wedge) * MAX_NEURONS + int'(rd.n_idx));
    assign n_wr_addr = wr.neuron[IW-1:0];
    assign n_rd_addr = rd.n_idx[IW-1:0];

    assign q = '{weight: weight_q, cls: cls_q, land: land_q, init: init_q};

    always_ff @(posedge aclk) begin
        if (wr.we_weight) begin
            weight_mem[w_wr_addr] <= wr.data;
        end
        if (rd.w_en) begin
            weight_q <= weight_mem[w_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.we_class) begin
            class_mem[n_wr_addr] <= wr.data[1:0];
        end
        if (rd.n_en) begin
            cls_q <= class_mem[n_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.we_land) begin
            land_mem[l_wr_addr] <= wr.data;
        end
        if (rd.n_en) begin
            land_q <= land_mem[l_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.we_init) begin
            init_mem[n_wr_addr] <= wr.data;
        end
        if (rd.n_en) begin
            init_q <= init_mem[n_rd_addr];
        end
    end
endmodule

FILE: sv/lifn_state_mem.sv
`timescale 1ns / 1ps
// Per-neuron potential, synaptic current and refractory memory; unwritten entries read as zero.
module lifn_state_mem #(
    parameter int MAX_NEURONS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_NEURONS)-1:0] rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_NEURONS)-1:0] wr_addr,
    input  lifn_pkg::nstate_t             wr_data,
    output lifn_pkg::nstate_t             rd_data
);
    lifn_pkg::nstate_t mem [MAX_NEURONS];
    logic [MAX_NEURONS-1:0] valid_reg;
    lifn_pkg::nstate_t data_q;
    logic valid_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_q  <= mem[rd_addr];
            valid_q <= valid_reg[rd_addr];
        end
    end

    assign rd_data = valid_q ? data_q : '0;
endmodule

FILE: tb/sv/tb_lif_spiking_network_tick.sv
`timescale 1ns / 1ps
// Self-checking testbench of the LIF network block: table loads, resets and ticks against a predictor.

class SpikeScoreboard;
    // register copies
    longint unsigned decay, leak, dt, refr_len, n_cfg, w_cfg;
    logic signed [31:0] thresh, reset_pot;
    // neuron state and tables
    logic signed [31:0] pot [64];
    logic signed [31:0] syn [64];
    logic [15:0]        refr [64];
    bit                 fired [64];
    logic signed [31:0] weight [64][64];
    logic [1:0]         cls [64];
    logic signed [31:0] land [8][64];
    logic signed [31:0] init_pot [64];
    logic [63:0]        mask_q [$];
    logic [6:0]         count_q [$];
    int                 errors;

    function new();
        decay = 58982; leak = 6554; dt = 65536; refr_len = 2; n_cfg = 64; w_cfg = 8;
        thresh = 65536; reset_pot = 0; errors = 0;
        for (int i = 0; i < 64; i++) begin
            pot[i] = 0; syn[i] = 0; refr[i] = 0; fired[i] = 0;
            cls[i] = 0; init_pot[i] = 0;
            for (int j = 0; j < 64; j++) weight[i][j] = 0;
            for (int w = 0; w < 8; w++) land[w][i] = 0;
        end
    endfunction

    function logic signed [31:0] qmul(logic signed [31:0] a, longint b);
        longint p;
        p = longint'(a) * b;
        p = p >>> 16;
        return p[31:0];
    endfunction

    function void write_reg(lifn_pkg::cfg_idx_t idx, logic [31:0] v);
        case (idx)
            lifn_pkg::CFG_SYN_DECAY: decay = v & 32'h1FFFF;
            lifn_pkg::CFG_LEAK:      leak = v & 32'h1FFFF;
            lifn_pkg::CFG_DT:        dt = v & 32'h1FFFF;
            lifn_pkg::CFG_THRESH:    thresh = v;
            lifn_pkg::CFG_RESET_POT: reset_pot = v;
            lifn_pkg::CFG_REFR_LEN:  refr_len = v & 32'hFFFF;
            lifn_pkg::CFG_NEURONS:   n_cfg = v & 32'h7F;
            lifn_pkg::CFG_WEDGES:    w_cfg = v & 32'hF;
            default: ;
        endcase
    endfunction

    function void note_input(lifn_pkg::cmd_t cmd, logic [151:0] d);
        int n, nw, lw;
        logic [31:0] acc;
        logic signed [31:0] s, ext, cur, lk, dv, val;
        logic [63:0] mask;
        logic [6:0] cnt;
        n = (n_cfg > 64) ? 64 : int'(n_cfg);
        nw = (w_cfg == 0) ? 1 : ((w_cfg > 8) ? 8 : int'(w_cfg));
        val = d[46:15];
        case (cmd)
            lifn_pkg::CMD_TICK: begin
                lw = int'(d[119:112]) % nw;
                mask = '0;
                cnt = '0;
                for (int i = 0; i < n; i++) begin
                    acc = '0;
                    for (int p = 0; p < n; p++) if (fired[p]) acc = acc + weight[p][i];
                    s = qmul(syn[i], longint'(decay)) + acc;
                    syn[i] = s;
                    ext = 0;
                    if (cls[i] == lifn_pkg::CLASS_LEFT) ext = d[78:47];
                    else if (cls[i] == lifn_pkg::CLASS_RIGHT) ext = d[110:79];
                    if (d[111]) ext = ext + qmul(d[151:120], longint'(land[lw][i]));
                    if (refr[i] == 0) begin
                        cur = s + ext;
                        lk = qmul(pot[i], longint'(leak));
                        dv = qmul(cur - lk, longint'(dt));
                        pot[i] = pot[i] + dv;
                    end
                end
                for (int i = 0; i < n; i++) begin
                    if (pot[i] >= thresh) begin
                        fired[i] = 1;
                        pot[i] = reset_pot;
                        refr[i] = refr_len[15:0];
                        mask[i] = 1'b1;
                        cnt++;
                    end else begin
                        fired[i] = 0;
                        if (refr[i] > 0) refr[i]--;
                    end
                end
                mask_q.push_back(mask);
                count_q.push_back(cnt);
            end
            lifn_pkg::CMD_RESET:
                for (int i = 0; i < n; i++) begin
                    pot[i] = init_pot[i]; syn[i] = 0; refr[i] = 0; fired[i] = 0;
                end
            lifn_pkg::CMD_WEIGHT:   weight[d[11:6]][d[5:0]] = val;
            lifn_pkg::CMD_CLASS:    cls[d[5:0]] = val[1:0];
            lifn_pkg::CMD_LANDMARK: land[d[14:12]][d[5:0]] = val;
            lifn_pkg::CMD_INIT:     init_pot[d[5:0]] = val;
            default: ;
        endcase
    endfunction

    function void check_result(logic [71:0] r);
        logic [63:0] em;
        logic [6:0]  ec;
        if (mask_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected spike result %h", r);
            return;
        end
        em = mask_q.pop_front();
        ec = count_q.pop_front();
        if (r[63:0] !== em || r[70:64] !== ec || r[71] !== 1'b0) begin
            errors++;
            if (errors <= 10)
                $display("spike mismatch: expected mask %h count %0d, got mask %h count %0d",
                         em, ec, r[63:0], r[70:64]);
        end
    endfunction

    function bit drained();
        return mask_q.size() == 0;
    endfunction
endclass

module tb_lif_spiking_network_tick;
    localparam longint CYCLE_LIMIT = 200_000;
    // Neurons and wedges whose table entries are loaded; ticks never reach past them.
    localparam int TB_NEURONS = 6;
    localparam int TB_WEDGES  = 4;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    SpikeScoreboard sb = new();
    int     tx_idle_pct = 30;
    int     rx_idle_pct = 72;
    bit     hold_off = 0;
    longint cycles = 0;

    lif_spiking_network_tick dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= !hold_off && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic logic [31:0] rand_q(int span);
        if ($urandom_range(0, 7) == 0) return $urandom();
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic send_item(lifn_pkg::cmd_t cmd, logic [151:0] d);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, d);
    endtask

    task automatic send_table(lifn_pkg::cmd_t cmd, int ni, int si, int wi, logic [31:0] v);
        logic [151:0] d;
        d = 152'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        d[5:0] = 6'(ni);
        d[11:6] = 6'(si);
        d[14:12] = 3'(wi);
        d[46:15] = v;
        send_item(cmd, d);
    endtask

    task automatic send_tick(logic [31:0] dl, logic [31:0] dr, bit lm, logic [7:0] lw,
                             logic [31:0] ls);
        logic [151:0] d;
        d = 152'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        d[78:47] = dl;
        d[110:79] = dr;
        d[111] = lm;
        d[119:112] = lw;
        d[151:120] = ls;
        send_item(lifn_pkg::CMD_TICK, d);
    endtask

    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            send_tick(rand_q(98304), rand_q(98304), 1'($urandom_range(0, 1)),
                      8'($urandom()), rand_q(65536));
        else if (r < 75)
            send_table(lifn_pkg::CMD_RESET, $urandom(), $urandom(), $urandom(), $urandom());
        else if (r < 80)
            send_table(lifn_pkg::CMD_WEIGHT, $urandom(), $urandom(), $urandom(),
                       rand_q(65536));
        else if (r < 85)
            send_table(lifn_pkg::CMD_CLASS, $urandom(), $urandom(), $urandom(),
                       $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3));
        else if (r < 90)
            send_table(lifn_pkg::CMD_LANDMARK, $urandom(), $urandom(), $urandom(),
                       rand_q(65536));
        else if (r < 95)
            send_table(lifn_pkg::CMD_INIT, $urandom(), $urandom(), $urandom(),
                       rand_q(131072));
        else
            send_table($urandom_range(0, 1) ? lifn_pkg::CMD_RSVD6 : lifn_pkg::CMD_RSVD7,
                       $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // A reset command with all neurons in use can outlast the last tick result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (!sb.drained()) @(posedge aclk);
        repeat (2 * 64 + 20) @(posedge aclk);
    endtask

    task automatic write_reg(lifn_pkg::cfg_idx_t idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic set_regs(logic [31:0] dec, logic [31:0] lk, logic [31:0] step,
                            logic [31:0] th, logic [31:0] rp, logic [31:0] rl,
                            logic [31:0] nc, logic [31:0] wc);
        write_reg(lifn_pkg::CFG_SYN_DECAY, dec);
        write_reg(lifn_pkg::CFG_LEAK, lk);
        write_reg(lifn_pkg::CFG_DT, step);
        write_reg(lifn_pkg::CFG_THRESH, th);
        write_reg(lifn_pkg::CFG_RESET_POT, rp);
        write_reg(lifn_pkg::CFG_REFR_LEN, rl);
        write_reg(lifn_pkg::CFG_NEURONS, nc);
        write_reg(lifn_pkg::CFG_WEDGES, wc);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Only a few neurons and wedges are used, and all of their entries are loaded first.
        write_reg(lifn_pkg::CFG_NEURONS, TB_NEURONS);
        write_reg(lifn_pkg::CFG_WEDGES, TB_WEDGES);
        for (int si = 0; si < TB_NEURONS; si++)
            for (int ni = 0; ni < TB_NEURONS; ni++)
                send_table(lifn_pkg::CMD_WEIGHT, ni, si, $urandom(), rand_q(32768));
        for (int ni = 0; ni < TB_NEURONS; ni++) begin
            send_table(lifn_pkg::CMD_CLASS, ni, $urandom(), $urandom(), $urandom_range(0, 3));
            send_table(lifn_pkg::CMD_INIT, ni, $urandom(), $urandom(), rand_q(131072));
            for (int w = 0; w < TB_WEDGES; w++)
                send_table(lifn_pkg::CMD_LANDMARK, ni, $urandom(), w, rand_q(65536));
        end

        // Directed part with every loaded neuron in use.
        send_table(lifn_pkg::CMD_RESET, 0, 0, 0, 0);
        send_tick(32'sh0001_8000, 32'sh0001_8000, 1'b1, 8'd255, 32'sh0001_0000);
        send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 8'd0, 32'h7FFF_FFFF);
        send_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 8'd7, 32'h8000_0000);
        send_table(lifn_pkg::CMD_CLASS, 63, 63, 7, 32'hFFFF_FFFF);
        send_table(lifn_pkg::CMD_CLASS, 0, 0, 0, 32'h7FFF_FFFC);
        send_table(lifn_pkg::CMD_WEIGHT, 63, 0, 0, 32'h7FFF_FFFF);
        send_table(lifn_pkg::CMD_WEIGHT, 0, 63, 0, 32'h8000_0000);
        send_table(lifn_pkg::CMD_LANDMARK, 63, 0, 7, 32'h8000_0000);
        send_table(lifn_pkg::CMD_INIT, 63, 0, 0, 32'h7FFF_FFFF);
        send_table(lifn_pkg::CMD_RSVD6, 5, 5, 5, 32'h1234_5678);
        send_table(lifn_pkg::CMD_RSVD7, 5, 5, 5, 32'h1234_5678);
        send_table(lifn_pkg::CMD_RESET, 0, 0, 0, 0);
        send_tick(32'h0, 32'h0, 1'b0, 8'd3, 32'h0);
        send_tick(32'sh0002_0000, -32'sh0002_0000, 1'b0, 8'd0, 32'h0);
        wait_idle();

        // No neurons in use and a zero wedge count; then an oversized wedge count and extremes.
        set_regs(0, 65536, 65536, 32'h8000_0000, 32'h7FFF_FFFF, 65535, 0, 0);
        send_table(lifn_pkg::CMD_RESET, 0, 0, 0, 0);
        send_tick(32'sh0001_0000, 32'sh0001_0000, 1'b1, 8'd9, 32'sh0001_0000);
        wait_idle();
        set_regs(65536, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, TB_NEURONS, 15);
        send_tick(32'sh0001_0000, 32'sh0001_0000, 1'b1, 8'd200, 32'sh0001_0000);
        send_table(lifn_pkg::CMD_RESET, 0, 0, 0, 0);
        send_tick(32'sh0001_0000, 32'sh0001_0000, 1'b1, 8'd202, 32'sh0001_0000);
        wait_idle();
        set_regs(0, 65536, 65536, 32'h8000_0000, 32'h7FFF_FFFF, 65535, 5, 1);
        send_tick(32'sh0001_0000, 32'sh0001_0000, 1'b1, 8'd1, 32'sh0001_0000);
        send_tick(32'h0, 32'h0, 1'b0, 8'd0, 32'h0);
        wait_idle();

        // Random part, a handful of register settings with few neurons in use.
        for (int ph = 0; ph < 7; ph++) begin
            tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 72 : 0;
            rx_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 30 : 0;
            set_regs($urandom_range(32768, 65536), $urandom_range(0, 20000),
                     $urandom_range(16384, 65536), $urandom_range(16384, 98304),
                     rand_q(32768), $urandom_range(0, 3), $urandom_range(2, TB_NEURONS),
                     $urandom_range(1, TB_WEDGES));
            send_table(lifn_pkg::CMD_RESET, 0, 0, 0, 0);
            if (ph == 5) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (800) @(posedge aclk);
                        hold_off = 0;
                    end
                    for (int k = 0; k < 12; k++) send_tick(rand_q(98304), rand_q(98304),
                                                          1'b1, 8'($urandom()),
                                                          rand_q(65536));
                join
            end
            for (int k = 0; k < 5; k++) send_random_item();
            wait_idle();
        end

        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.drained())
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
